[design/cdsi_pkg.sv]
// ----------------------------------------------------------------------------
// cdsi_pkg
// Shared types and constants for the checked decimal text to integer converter.
// ----------------------------------------------------------------------------
package cdsi_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned ACC_W    = 34;
    localparam int unsigned VALUE_W  = 33;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned TDATA_W  = 40;

    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = 2;
    localparam int unsigned QCNT_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_SAT     = 4'd12;
    localparam logic [COUNT_W-1:0] MAX_DIGITS    = 4'd10;
    localparam logic [COUNT_W-1:0] MAX_NEG_CHARS = 4'd11;

    localparam logic [ACC_W-1:0] UNSIGNED_LIMIT = 34'd4294967295;
    localparam logic [ACC_W-1:0] POS_LIMIT      = 34'd2147483647;
    localparam logic [ACC_W-1:0] NEG_LIMIT      = 34'd2147483648;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_MINUS,
        KIND_NUL,
        KIND_OTHER
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_NONDIGIT = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } item_t;

endpackage

[design/checked_decimal_string_to_int_top.sv]
// ----------------------------------------------------------------------------
// checked_decimal_string_to_int_top
// Decimal text to 32-bit integer converter with length and range checks.
// ----------------------------------------------------------------------------
// Feed the text one byte per beat with tlast on the buffer's final byte; each
// final byte yields one result beat carrying the value and a status code (the
// value is zero whenever the status is not ok). One byte is taken every cycle
// unless a result beat stalls: the parser's multiply-by-ten accumulate uses
// shifts and adds, and a four-entry queue between the input stage and the
// parser absorbs output stalls. The final byte passes through the input stage
// register and the queue before the parser registers the result. signed_mode
// is sampled when the final byte is parsed and should be written while idle.
module checked_decimal_string_to_int_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,   // signed_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdsi_pkg::BYTE_W-1:0]   s_tdata,       // [7:0] text_byte
    input  logic                          s_tlast,       // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdsi_pkg::TDATA_W-1:0]  m_tdata,       // [32:0] parsed_value
    output logic [cdsi_pkg::STATUS_W-1:0] m_tuser        // [2:0] status_code
);
    import cdsi_pkg::*;

    logic               signed_mode_reg, signed_mode_next;
    logic               f_valid, q_ready, q_valid, q_pop;
    item_t              f_item, q_item;
    logic [VALUE_W-1:0] value;
    status_t            status;

    assign signed_mode_next = cfg_wr_en ? cfg_wr_data : signed_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b1;
        end else begin
            signed_mode_reg <= signed_mode_next;
        end
    end

    cdsi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_ready (q_ready)
    );

    cdsi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_item  (f_item),
        .push_ready (q_ready),
        .head_valid (q_valid),
        .head_item  (q_item),
        .pop        (q_pop)
    );

    cdsi_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .signed_mode (signed_mode_reg),
        .head_valid  (q_valid),
        .head_item   (q_item),
        .pop         (q_pop),
        .res_valid   (m_tvalid),
        .res_value   (value),
        .res_status  (status),
        .res_ready   (m_tready)
    );

    assign m_tdata = {{(TDATA_W-VALUE_W){1'b0}}, value};
    assign m_tuser = status;

endmodule

[design/cdsi_front.sv]
// ----------------------------------------------------------------------------
// cdsi_front
// Input stage: takes one text byte a beat and registers its class.
// ----------------------------------------------------------------------------
module cdsi_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cdsi_pkg::BYTE_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        out_valid,
    output cdsi_pkg::item_t             out_item,
    input  logic                        out_ready
);
    import cdsi_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    item_t cls;
    logic  take;

    always_comb begin
        cls.last  = s_tlast;
        cls.digit = DIGIT_W'(s_tdata - CHAR_ZERO);
        if (s_tdata == CHAR_NUL) begin
            cls.kind = KIND_NUL;
        end else if (s_tdata == CHAR_MINUS) begin
            cls.kind = KIND_MINUS;
        end else if (s_tdata inside {[CHAR_ZERO:CHAR_NINE]}) begin
            cls.kind = KIND_DIGIT;
        end else begin
            cls.kind = KIND_OTHER;
        end
    end

    assign s_tready = !valid_reg || out_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next = 1'b1;
            item_next  = cls;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[design/cdsi_queue.sv]
// ----------------------------------------------------------------------------
// cdsi_queue
// Short queue of classified bytes between the input stage and the parser.
// ----------------------------------------------------------------------------
module cdsi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  cdsi_pkg::item_t push_item,
    output logic            push_ready,
    output logic            head_valid,
    output cdsi_pkg::item_t head_item,
    input  logic            pop
);
    import cdsi_pkg::*;

    item_t              slots [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/cdsi_back.sv]
// ----------------------------------------------------------------------------
// cdsi_back
// Parser: accumulates digits, tracks length and errors, and registers one
// result per buffer.
// ----------------------------------------------------------------------------
module cdsi_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          signed_mode,
    input  logic                          head_valid,
    input  cdsi_pkg::item_t               head_item,
    output logic                          pop,
    output logic                          res_valid,
    output logic [cdsi_pkg::VALUE_W-1:0]  res_value,
    output cdsi_pkg::status_t             res_status,
    input  logic                          res_ready
);
    import cdsi_pkg::*;

    logic [ACC_W-1:0]   mag_reg, mag_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               minus_reg, minus_next;
    logic               term_reg, term_next;
    logic               bad_reg, bad_next;
    logic               start_reg, start_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;

    logic [ACC_W-1:0]   mag_cur;
    logic [COUNT_W-1:0] cnt_cur, digits;
    logic               minus_cur, term_cur, bad_cur;
    logic [ACC_W-1:0]   neg_mag;
    logic [VALUE_W-1:0] fin_value;
    status_t            fin_status;

    // A result may only move when the output register has room.
    assign pop = head_valid && (!head_item.last || !out_valid_reg || res_ready);

    // Buffer state as seen by this byte: cleared at the start of a buffer.
    always_comb begin
        mag_cur   = start_reg ? '0   : mag_reg;
        cnt_cur   = start_reg ? '0   : cnt_reg;
        minus_cur = start_reg ? 1'b0 : minus_reg;
        term_cur  = start_reg ? 1'b0 : term_reg;
        bad_cur   = start_reg ? 1'b0 : bad_reg;
        digits    = cnt_cur - COUNT_W'(minus_cur);
    end

    always_comb begin
        mag_next   = mag_cur;
        cnt_next   = cnt_cur;
        minus_next = minus_cur;
        term_next  = term_cur;
        bad_next   = bad_cur;
        if (!term_cur) begin
            if (head_item.kind == KIND_NUL) begin
                term_next = 1'b1;
            end else begin
                if (cnt_cur == '0 && head_item.kind == KIND_MINUS) begin
                    minus_next = 1'b1;
                end else if (head_item.kind == KIND_DIGIT) begin
                    if (digits < MAX_DIGITS) begin
                        mag_next = (mag_cur << 3) + (mag_cur << 1)
                                 + ACC_W'(head_item.digit);
                    end
                end else begin
                    bad_next = 1'b1;
                end
                if (cnt_cur < COUNT_SAT) begin
                    cnt_next = cnt_cur + 1'b1;
                end
            end
        end
    end

    // Final checks in priority order: empty, length, character, range.
    always_comb begin
        neg_mag    = '0 - mag_next;
        fin_value  = '0;
        fin_status = ST_OK;
        if (cnt_next == '0) begin
            fin_status = ST_EMPTY;
        end else if (signed_mode && minus_next) begin
            if (cnt_next == 4'd1 || cnt_next > MAX_NEG_CHARS) begin
                fin_status = ST_BAD_LEN;
            end else if (bad_next) begin
                fin_status = ST_NONDIGIT;
            end else if (mag_next > NEG_LIMIT) begin
                fin_status = ST_RANGE;
            end else begin
                fin_value = neg_mag[VALUE_W-1:0];
            end
        end else begin
            if (cnt_next > MAX_DIGITS) begin
                fin_status = ST_BAD_LEN;
            end else if (bad_next || minus_next) begin
                fin_status = ST_NONDIGIT;
            end else if (mag_next > (signed_mode ? POS_LIMIT : UNSIGNED_LIMIT)) begin
                fin_status = ST_RANGE;
            end else begin
                fin_value = mag_next[VALUE_W-1:0];
            end
        end
    end

    always_comb begin
        start_next      = start_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (res_ready) begin
            out_valid_next = 1'b0;
        end
        if (pop) begin
            start_next = head_item.last;
            if (head_item.last) begin
                out_valid_next  = 1'b1;
                out_value_next  = fin_value;
                out_status_next = fin_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
        if (pop) begin
            mag_reg   <= mag_next;
            cnt_reg   <= cnt_next;
            minus_reg <= minus_next;
            term_reg  <= term_next;
            bad_reg   <= bad_next;
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_value  = out_value_reg;
    assign res_status = out_status_reg;

endmodule

[tb/sv/checked_decimal_string_to_int_top_tb.sv]
// ----------------------------------------------------------------------------
// checked_decimal_string_to_int_top_tb
// Self-checking bench for the decimal text to integer converter.
// Text buffers go in through a bursty stream driver. A scoreboard parses every
// accepted byte with its own copy of the parser state and compares each result
// beat against the oldest predicted value and status. Directed buffers cover
// the range limits and each error path. Random phases in both parse modes
// follow, mixing well-formed numbers with corrupted and noise buffers.
// ----------------------------------------------------------------------------
module checked_decimal_string_to_int_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdsi_pkg::*;

    localparam int unsigned RANDOM_BEATS   = 900;
    localparam int unsigned PHASE_BEATS    = 150;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef struct {
        logic [BYTE_W-1:0] text;
        logic              last;
    } text_beat_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } parse_result_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata     = '0;
    logic                s_tlast     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    text_beat_t    pending_text[$];
    parse_result_t expected_parses[$];
    logic [BYTE_W-1:0] draft_text[$];

    int unsigned queued_beats = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;

    // parser shadow state
    logic               signed_shadow;
    logic [ACC_W-1:0]   magnitude;
    logic [COUNT_W-1:0] char_total;
    logic               minus_lead;
    logic               nul_hit;
    logic               bad_char;
    logic               buffer_start;

    // driver and receiver pacing
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;
    text_beat_t    next_beat;
    parse_result_t oldest_parse;

    always #1 aclk = ~aclk;

    checked_decimal_string_to_int_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Update the shadow parser with one accepted byte; on the final byte,
    // queue the value and status the block must return.
    task automatic parse_text_beat(input logic [BYTE_W-1:0] b, input logic last);
        parse_result_t      res;
        logic [COUNT_W-1:0] digits;
        if (buffer_start) begin
            magnitude  = '0;
            char_total = '0;
            minus_lead = 1'b0;
            nul_hit    = 1'b0;
            bad_char   = 1'b0;
            buffer_start = 1'b0;
        end
        if (!nul_hit) begin
            if (b == CHAR_NUL) begin
                nul_hit = 1'b1;
            end else begin
                if (char_total == 0 && b == CHAR_MINUS) begin
                    minus_lead = 1'b1;
                end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    digits = char_total - COUNT_W'(minus_lead);
                    // digits past the tenth cannot pass the length check
                    if (digits < MAX_DIGITS)
                        magnitude = magnitude * 10 + ACC_W'(b - CHAR_ZERO);
                end else begin
                    bad_char = 1'b1;
                end
                if (char_total < COUNT_SAT)
                    char_total = char_total + 1'b1;
            end
        end
        if (last) begin
            res.value = '0;
            if (char_total == 0) begin
                res.status = ST_EMPTY;
            end else if (signed_shadow && minus_lead) begin
                if (char_total == 1 || char_total > MAX_NEG_CHARS)
                    res.status = ST_BAD_LEN;
                else if (bad_char)
                    res.status = ST_NONDIGIT;
                else if (magnitude > NEG_LIMIT)
                    res.status = ST_RANGE;
                else begin
                    res.status = ST_OK;
                    res.value  = VALUE_W'(0) - magnitude[VALUE_W-1:0];
                end
            end else if (char_total > MAX_DIGITS) begin
                res.status = ST_BAD_LEN;
            end else if (bad_char || minus_lead) begin
                res.status = ST_NONDIGIT;
            end else if (magnitude > (signed_shadow ? POS_LIMIT : UNSIGNED_LIMIT)) begin
                res.status = ST_RANGE;
            end else begin
                res.status = ST_OK;
                res.value  = magnitude[VALUE_W-1:0];
            end
            expected_parses.push_back(res);
            buffer_start = 1'b1;
        end
    endtask

    // Scoreboard: predict on input beats, check on result beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            signed_shadow = 1'b1;
            magnitude     = '0;
            char_total    = '0;
            minus_lead    = 1'b0;
            nul_hit       = 1'b0;
            bad_char      = 1'b0;
            buffer_start  = 1'b1;
        end else begin
            if (cfg_wr_en)
                signed_shadow = cfg_wr_data;
            if (s_tvalid && s_tready)
                parse_text_beat(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_parses.size() == 0) begin
                    $display("%0t: result beat with none pending: value %0d status %0d",
                             $time, $signed(m_tdata[VALUE_W-1:0]), m_tuser);
                    mismatches++;
                end else begin
                    oldest_parse = expected_parses.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== oldest_parse.value) begin
                        $display("%0t: parsed_value mismatch: expected %0d got %0d", $time,
                                 $signed(oldest_parse.value), $signed(m_tdata[VALUE_W-1:0]));
                        mismatches++;
                    end
                    if (m_tuser !== oldest_parse.status) begin
                        $display("%0t: status_code mismatch: expected %0d (%s) got %0d",
                                 $time, oldest_parse.status, oldest_parse.status.name(),
                                 m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[TDATA_W-1:VALUE_W] !== '0) begin
                        $display("%0t: tdata padding mismatch: expected 0 got %0h",
                                 $time, m_tdata[TDATA_W-1:VALUE_W]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Driver: bursts of beats separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_text.size() != 0) begin
                next_beat = pending_text.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_beat.text;
                s_tlast  <= next_beat.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        9:          gap_left = $urandom_range(5, 20);
                        default:    gap_left = $urandom_range(1, 4);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch between always ready, light stalls and heavy stalls.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            draft_text.push_back(s[i]);
    endtask

    task automatic add_noise(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            draft_text.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Move the drafted buffer to the driver, flagging its final byte.
    task automatic close_buffer();
        text_beat_t beat;
        for (int i = 0; i < draft_text.size(); i++) begin
            beat.text = draft_text[i];
            beat.last = (i == draft_text.size() - 1);
            pending_text.push_back(beat);
        end
        queued_beats += draft_text.size();
        draft_text.delete();
    endtask

    task automatic directed_buffer(input string s);
        add_str(s);
        close_buffer();
    endtask

    task automatic write_signed_mode(input logic mode);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Sample away from the rising edge so the driver and scoreboard have settled.
    task automatic wait_idle();
        while (pending_text.size() != 0 || s_tvalid || expected_parses.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Draft a decimal number, biased toward the range limits.
    task automatic add_number();
        longint v;
        case ($urandom_range(0, 6))
            0:       v = $urandom_range(0, 9);
            1:       v = $urandom_range(0, 99999);
            2:       v = longint'($urandom);
            3:       v = 64'd2147483647 + $urandom_range(0, 6) - 3;
            4:       v = 64'd4294967295 + $urandom_range(0, 6) - 3;
            5:       v = longint'($urandom_range(0, 999999)) * 10000 + $urandom_range(0, 9999);
            default: v = longint'($urandom_range(0, 99)) * 100000000 + $urandom_range(0, 99999999);
        endcase
        if ($urandom_range(0, 1))
            add_str("-");
        if ($urandom_range(0, 9) == 0)
            add_str("0");
        add_str($sformatf("%0d", v));
    endtask

    task automatic random_buffer();
        int unsigned pos;
        case ($urandom_range(0, 9))
            7: begin
                add_noise($urandom_range(1, 14));
            end
            8: begin
                // corrupt a number with one stray byte
                add_number();
                pos = $urandom_range(0, draft_text.size());
                case ($urandom_range(0, 3))
                    0:       draft_text.insert(pos, "+");
                    1:       draft_text.insert(pos, " ");
                    2:       draft_text.insert(pos, "-");
                    default: draft_text.insert(pos, BYTE_W'($urandom_range(1, 255)));
                endcase
            end
            9: begin
                case ($urandom_range(0, 3))
                    0: draft_text.push_back(CHAR_NUL);
                    1: add_str("-");
                    2: add_str($sformatf("%0d%0d", $urandom_range(100, 999),
                                        $urandom_range(100000000, 999999999)));
                    default: add_str($sformatf("-%0d%0d", $urandom_range(100, 999),
                                             $urandom_range(100000000, 999999999)));
                endcase
                if ($urandom_range(0, 1)) begin
                    draft_text.push_back(CHAR_NUL);
                    add_noise($urandom_range(0, 3));
                end
            end
            default: begin
                add_number();
                if ($urandom_range(0, 4) == 0) begin
                    draft_text.push_back(CHAR_NUL);
                    add_noise($urandom_range(0, 4));
                end
            end
        endcase
        close_buffer();
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned phase_index;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // signed mode out of reset
        directed_buffer("-2147483648");
        directed_buffer("2147483647");
        directed_buffer("2147483648");
        directed_buffer("-2147483649");
        directed_buffer("-");
        draft_text.push_back(CHAR_NUL);
        close_buffer();
        directed_buffer("-12345678901234");
        directed_buffer("12345678901");
        directed_buffer("+5");
        directed_buffer("1 2");
        add_str("12");
        draft_text.push_back(CHAR_NUL);
        draft_text.push_back(8'hff);
        close_buffer();
        directed_buffer("-0");
        draft_text.push_back(8'hff);
        close_buffer();
        wait_idle();

        write_signed_mode(1'b0);
        directed_buffer("4294967295");
        directed_buffer("4294967296");
        directed_buffer("-1");
        directed_buffer("9999999999");
        directed_buffer("0");
        directed_buffer("12-3");
        wait_idle();

        write_signed_mode(1'b1);
        directed_buffer("-2147483647");
        directed_buffer("-12-3");
        wait_idle();

        queued_beats = 0;
        phase_index  = 0;
        while (queued_beats < RANDOM_BEATS) begin
            case (phase_index)
                0:       write_signed_mode(1'b0);
                1:       write_signed_mode(1'b1);
                default: write_signed_mode($urandom_range(0, 1));
            endcase
            phase_start = queued_beats;
            while (queued_beats - phase_start < PHASE_BEATS && queued_beats < RANDOM_BEATS)
                random_buffer();
            wait_idle();
            phase_index++;
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
